FILE: src/srm_pkg.sv
// Shared types and constants for the SOME/IP stream message reassembler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package srm_pkg;

    // Ring geometry
    localparam int C_RING_DEPTH   = 4096;
    localparam int C_HEADER_BYTES = 16;
    localparam int C_PTR_W        = $clog2(C_RING_DEPTH);
    localparam int C_CNT_W        = C_PTR_W + 1;

    // Fixed field widths
    localparam int C_CAP_W   = 13;
    localparam int C_LEN_W   = 33;
    localparam int C_SHIFT_W = 32;
    localparam int C_WIDE_W  = (C_CNT_W > C_CAP_W) ? C_CNT_W : C_CAP_W;

    // Reset value of the capacity register
    localparam logic [C_CAP_W-1:0] C_CAP_RESET = C_CAP_W'(4096);

    // Operation codes
    localparam logic C_OP_PUSH = 1'b0;
    localparam logic C_OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] C_ST_OK    = 2'd0;
    localparam logic [1:0] C_ST_DONE  = 2'd1;
    localparam logic [1:0] C_ST_CLEAR = 2'd2;
    localparam logic [1:0] C_ST_FULL  = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic push;        // perform a push with the accepted word
        logic pop;         // read the ring and advance the read pointer
        logic load_direct; // load the result of this cycle's word
        logic load_mem;    // load the popped entry from the read register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic ring_empty;  // nothing committed
    } t_sts;

    // One result word
    typedef struct packed {
        logic [1:0]         status;
        logic [C_LEN_W-1:0] message_length;
        logic [7:0]         read_byte;
        logic               read_last;
    } t_result;

endpackage

FILE: src/srm_if.sv
// Channel interfaces: input words, result words and the capacity write port.
// Depends on srm_pkg for field widths.
interface srm_in_if import srm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    modport source (output valid, operation, data_byte, input ready);
    modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface srm_out_if import srm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [C_LEN_W-1:0] message_length;
    logic [7:0]         read_byte;
    logic               read_last;
    modport source (output valid, status, message_length, read_byte, read_last, input ready);
    modport sink   (input valid, status, message_length, read_byte, read_last, output ready);
endinterface

interface srm_cfg_if import srm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [C_CAP_W-1:0] capacity_in_use;
    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

FILE: src/srm_ctrl.sv
// Controller for the reassembler: accept handshake, pop read sequencing and
// output valid. Depends on srm_pkg for the command and status structs.
module srm_ctrl import srm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_operation,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    // Take a word only when idle and the result slot is empty or frees up this cycle
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Issue commands
    always_comb begin
        o_cmd.push        = accept && (i_operation == C_OP_PUSH);
        o_cmd.pop         = accept && (i_operation == C_OP_POP) && !i_sts.ring_empty;
        o_cmd.load_direct = accept && !o_cmd.pop;
        o_cmd.load_mem    = (r_state == S_READ);
    end

    // Advance state and hold the result valid until taken
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load_direct || o_cmd.load_mem) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // Result slot is free while the ring read is in flight
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result pending during ring read");

    // A pop of a committed byte always passes through the read state and then delivers a result
    a_pop_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |=> (r_state == S_READ) ##1 r_out_valid)
        else $error("pop did not load a result");

    // No new word enters during the ring read
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_in_ready)
        else $error("word accepted during ring read");
`endif

endmodule

FILE: src/srm_datapath.sv
// Datapath for the reassembler: ring memory, pointers, counts, header length
// shift, capacity register and result register. Depends on srm_pkg.
module srm_datapath import srm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_operation,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_we,
    input  logic [C_CAP_W-1:0] i_cfg_data,
    output t_sts               o_sts,
    output t_result            o_result
);

    // Ring memory: {last mark, byte}
    logic [8:0] ring_mem [C_RING_DEPTH];
    logic [8:0] r_rdata;

    logic [C_PTR_W-1:0]   r_wp, r_rp;
    logic [C_CNT_W-1:0]   r_comm, r_pend;
    logic [C_SHIFT_W-1:0] r_shift;
    logic [C_CAP_W-1:0]   r_cap;
    t_result              r_result;

    logic                 full, in_len, done, clear;
    logic [C_CNT_W:0]     occupancy;
    logic [C_CNT_W-1:0]   pend1;
    logic [C_SHIFT_W-1:0] shift_new;
    logic [C_LEN_W-1:0]   total_raw, total;
    logic [C_WIDE_W-1:0]  cap_eff;
    logic [C_PTR_W-1:0]   waddr;
    t_result              push_res;

    // Decode a push
    always_comb begin
        occupancy = {1'b0, r_comm} + {1'b0, r_pend};
        full      = occupancy >= (C_CNT_W+1)'(C_RING_DEPTH);
        in_len    = (r_pend >= C_CNT_W'(4)) && (r_pend < C_CNT_W'(8));
        shift_new = in_len ? {r_shift[C_SHIFT_W-9:0], i_data_byte} : r_shift;
        pend1     = r_pend + C_CNT_W'(1);
        total_raw = {1'b0, shift_new} + C_LEN_W'(8);
        total     = (total_raw < C_LEN_W'(C_HEADER_BYTES)) ? C_LEN_W'(C_HEADER_BYTES)
                                                           : total_raw;
        done      = (pend1 >= C_CNT_W'(C_HEADER_BYTES))
                 && (C_LEN_W'(pend1) == total);
        cap_eff   = (C_WIDE_W'(r_cap) > C_WIDE_W'(C_RING_DEPTH)) ? C_WIDE_W'(C_RING_DEPTH)
                                                                 : C_WIDE_W'(r_cap);
        clear     = C_WIDE_W'(pend1) >= cap_eff;
        waddr     = r_wp + r_pend[C_PTR_W-1:0];

        push_res.message_length = '0;
        push_res.read_byte      = '0;
        push_res.read_last      = 1'b0;
        priority if (full) begin
            push_res.status = C_ST_FULL;
        end else if (done) begin
            push_res.status         = C_ST_DONE;
            push_res.message_length = total;
        end else if (clear) begin
            push_res.status = C_ST_CLEAR;
        end else begin
            push_res.status = C_ST_OK;
        end
    end

    assign o_sts.ring_empty = (r_comm == '0);
    assign o_result         = r_result;

    // Write and read the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            ring_mem[waddr] <= {done, i_data_byte};
        end
        if (i_cmd.pop) begin
            r_rdata <= ring_mem[r_rp];
        end
    end

    // Update pointers, counts and header length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_comm  <= '0;
            r_pend  <= '0;
            r_shift <= '0;
            r_cap   <= C_CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.push && !full) begin
                if (done) begin
                    r_wp    <= r_wp + pend1[C_PTR_W-1:0];
                    r_comm  <= r_comm + pend1;
                    r_pend  <= '0;
                    r_shift <= '0;
                end else if (clear) begin
                    r_pend  <= '0;
                    r_shift <= '0;
                end else begin
                    r_pend  <= pend1;
                    r_shift <= shift_new;
                end
            end
            if (i_cmd.pop) begin
                r_rp   <= r_rp + C_PTR_W'(1);
                r_comm <= r_comm - C_CNT_W'(1);
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mem) begin
            r_result.status         <= C_ST_OK;
            r_result.message_length <= '0;
            r_result.read_byte      <= r_rdata[7:0];
            r_result.read_last      <= r_rdata[8];
        end else if (i_cmd.load_direct) begin
            if (i_operation == C_OP_POP) begin
                r_result.status         <= C_ST_FULL;
                r_result.message_length <= '0;
                r_result.read_byte      <= '0;
                r_result.read_last      <= 1'b0;
            end else begin
                r_result <= push_res;
            end
        end
    end

`ifndef SYNTHESIS
    // Committed plus tail bytes never exceed the ring
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (C_CNT_W+1)'(C_RING_DEPTH))
        else $error("ring occupancy overflow");

    // A completed message commits exactly its tail
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !full && done) |=> (r_pend == '0) && (r_comm == $past(r_comm) + $past(pend1)))
        else $error("commit count mismatch");

    // A pop only happens with committed bytes
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_comm != '0))
        else $error("pop from empty ring");
`endif

endmodule

FILE: src/someip_stream_message_reassembler_top.sv
// SOME/IP stream message reassembler: top level joining controller and datapath.
// Depends on srm_pkg, the channel interfaces, srm_ctrl and srm_datapath.
//
// Stream bytes are pushed one word at a time and cut into SOME/IP messages
// using the big-endian length in header bytes 4 to 7 (message size = length
// + 8, at least 16). Completed messages sit in a 4096-entry ring and are popped
// byte by byte with a last mark. A push result is loaded directly; a pop of a
// committed byte first passes the registered read port of the ring memory and
// the read state. A new word is taken as soon as the previous result is taken
// or leaves the result register that same cycle, while no ring read is in
// flight. The ring needs no clearing after reset. The capacity register accepts
// a write in every cycle and should be written only while the block is idle.
module someip_stream_message_reassembler_top import srm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    srm_in_if.sink   i_in,
    srm_out_if.source o_out,
    srm_cfg_if.sink  i_cfg
);

    t_cmd    cmd;
    t_sts    sts;
    t_result result;
    logic    in_ready, out_valid;

    srm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    srm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_in.operation),
        .i_data_byte (i_in.data_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.capacity_in_use),
        .o_sts       (sts),
        .o_result    (result)
    );

    // Drive channel handshakes and result payload
    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = out_valid;
    assign o_out.status         = result.status;
    assign o_out.message_length = result.message_length;
    assign o_out.read_byte      = result.read_byte;
    assign o_out.read_last      = result.read_last;

endmodule
